/* design/sm83_pkg.sv */
`timescale 1ns / 1ps

package sm83_pkg;

  localparam int unsigned FcW = 17;

  // supported opcodes
  localparam logic [7:0] OP_NOP      = 8'h00;
  localparam logic [7:0] OP_JP_A16   = 8'hC3;
  localparam logic [7:0] OP_XOR_A    = 8'hAF;
  localparam logic [7:0] OP_LD_HL    = 8'h21;
  localparam logic [7:0] OP_LD_C     = 8'h0E;
  localparam logic [7:0] OP_LD_B     = 8'h06;
  localparam logic [7:0] OP_LDD_HL_A = 8'h32;
  localparam logic [7:0] OP_DEC_B    = 8'h05;
  localparam logic [7:0] OP_DEC_C    = 8'h0D;
  localparam logic [7:0] OP_JR_NZ    = 8'h20;

  // flag bit positions
  localparam int unsigned FlagZ = 3;
  localparam int unsigned FlagN = 2;
  localparam int unsigned FlagH = 1;
  localparam int unsigned FlagC = 0;

  localparam logic [4:0] COST_4  = 5'd4;
  localparam logic [4:0] COST_8  = 5'd8;
  localparam logic [4:0] COST_12 = 5'd12;
  localparam logic [4:0] COST_16 = 5'd16;

  localparam logic [7:0]     RST_A     = 8'h01;
  localparam logic [3:0]     RST_FLAGS = 4'hB;
  localparam logic [7:0]     RST_B     = 8'h00;
  localparam logic [7:0]     RST_C     = 8'h13;
  localparam logic [15:0]    RST_HL    = 16'h014D;
  localparam logic [15:0]    RST_PC    = 16'h0100;
  localparam logic [FcW-1:0] RST_LIMIT = 17'd69905;

  typedef struct packed {
    logic [7:0]     a;
    logic [3:0]     flags;
    logic [7:0]     b;
    logic [7:0]     c;
    logic [15:0]    hl;
    logic [15:0]    pc;
    logic [FcW-1:0] frame_cycles;
  } cpu_state_t;

  typedef struct packed {
    logic        illegal;
    logic        frame_end;
    logic [3:0]  flags_out;
    logic [4:0]  cycle_cost;
    logic [7:0]  write_data;
    logic [15:0] write_addr;
    logic        write_valid;
    logic [15:0] next_pc;
  } exec_result_t;

endpackage

/* design/sm83_subset_instruction_execute.sv */
`timescale 1ns / 1ps

// channel   | direction | payload
// in_       | slave     | in_tdata: opcode, imm_low, imm_high
// out_      | master    | out_tdata: next_pc .. illegal, one result per instruction
// cfg_      | write     | frame_cycle_limit
//
// one instruction per clock unless stalled: input register, execute logic, result register.
// out_tvalid rises as an instruction enters the result register; it transfers on out_tready.
// the register file and flags update as an instruction moves into the result register.
// a stalled result stage holds one pending instruction in the input register.
// rst_n is synchronous; state returns to its power-on values.

module sm83_subset_instruction_execute (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // opcode[7:0], imm_low[15:8], imm_high[23:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  // next_pc[15:0], write_valid[16], write_addr[32:17], write_data[40:33],
  // cycle_cost[45:41], flags_out[49:46], frame_end[50], illegal[51], zero fill
  output logic [55:0] out_tdata,
  input  logic        cfg_wr_en,
  input  logic [16:0] cfg_wr_data
);
  import sm83_pkg::*;

  logic               in_v_r;
  logic [23:0]        in_d_r;
  logic               out_v_r;
  exec_result_t       res_r;
  exec_result_t       res_nxt;
  cpu_state_t         state_r;
  cpu_state_t         state_nxt;
  logic [FcW-1:0]     limit_r;
  logic               advance;

  assign advance   = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || advance;

  sm83_exec u_exec (
    .cur_state         (state_r),
    .opcode            (in_d_r[7:0]),
    .imm_low           (in_d_r[15:8]),
    .imm_high          (in_d_r[23:16]),
    .frame_cycle_limit (limit_r),
    .new_state         (state_nxt),
    .result            (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      limit_r <= RST_LIMIT;
      state_r <= '{a: RST_A, flags: RST_FLAGS, b: RST_B, c: RST_C,
                   hl: RST_HL, pc: RST_PC, frame_cycles: '0};
    end else begin
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      if (in_tready) begin
        in_v_r <= in_tvalid;
      end
      if (advance) begin
        out_v_r <= 1'b1;
        state_r <= state_nxt;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_d_r <= in_tdata;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {4'b0000, res_r};

endmodule

/* design/sm83_exec.sv */
`timescale 1ns / 1ps

module sm83_exec (
  input  sm83_pkg::cpu_state_t        cur_state,
  input  logic [7:0]                  opcode,
  input  logic [7:0]                  imm_low,
  input  logic [7:0]                  imm_high,
  input  logic [sm83_pkg::FcW-1:0]    frame_cycle_limit,
  output sm83_pkg::cpu_state_t        new_state,
  output sm83_pkg::exec_result_t      result
);
  import sm83_pkg::*;

  logic [15:0]  imm16;
  logic [15:0]  jr_off;
  logic [7:0]   dec_src;
  logic [7:0]   dec_val;
  logic [3:0]   dec_flags;
  logic [15:0]  pc_nxt;
  logic [4:0]   cost;
  logic         ill;
  logic [FcW:0] cyc_sum;
  logic         fend;
  cpu_state_t   core_state;
  logic         wr_valid;
  logic [15:0]  wr_addr;
  logic [7:0]   wr_data;

  assign imm16  = {imm_high, imm_low};
  assign jr_off = {{8{imm_low[7]}}, imm_low};

  // shared decrement for DEC B / DEC C
  assign dec_src = (opcode == OP_DEC_B) ? cur_state.b : cur_state.c;
  assign dec_val = dec_src - 8'd1;
  always_comb begin
    dec_flags        = 4'h0;
    dec_flags[FlagZ] = (dec_val == 8'h00);
    dec_flags[FlagN] = 1'b1;
    dec_flags[FlagH] = (dec_src[3:0] == 4'h0);
    dec_flags[FlagC] = cur_state.flags[FlagC];
  end

  always_comb begin
    core_state = cur_state;
    pc_nxt     = cur_state.pc;
    cost       = 5'd0;
    ill        = 1'b0;
    wr_valid   = 1'b0;
    wr_addr    = 16'h0000;
    wr_data    = 8'h00;
    case (opcode)
      OP_NOP: begin
        pc_nxt = cur_state.pc + 16'd1;
        cost   = COST_4;
      end
      OP_JP_A16: begin
        pc_nxt = imm16;
        cost   = COST_16;
      end
      OP_XOR_A: begin
        core_state.a            = 8'h00;
        core_state.flags        = 4'h0;
        core_state.flags[FlagZ] = 1'b1;
        pc_nxt                  = cur_state.pc + 16'd1;
        cost                    = COST_4;
      end
      OP_LD_HL: begin
        core_state.hl = imm16;
        pc_nxt        = cur_state.pc + 16'd3;
        cost          = COST_12;
      end
      OP_LD_C: begin
        core_state.c = imm_low;
        pc_nxt       = cur_state.pc + 16'd2;
        cost         = COST_8;
      end
      OP_LD_B: begin
        core_state.b = imm_low;
        pc_nxt       = cur_state.pc + 16'd2;
        cost         = COST_8;
      end
      OP_LDD_HL_A: begin
        wr_valid      = 1'b1;
        wr_addr       = cur_state.hl;
        wr_data       = cur_state.a;
        core_state.hl = cur_state.hl - 16'd1;
        pc_nxt        = cur_state.pc + 16'd1;
        cost          = COST_8;
      end
      OP_DEC_B: begin
        core_state.b     = dec_val;
        core_state.flags = dec_flags;
        pc_nxt           = cur_state.pc + 16'd1;
        cost             = COST_4;
      end
      OP_DEC_C: begin
        core_state.c     = dec_val;
        core_state.flags = dec_flags;
        pc_nxt           = cur_state.pc + 16'd1;
        cost             = COST_4;
      end
      OP_JR_NZ: begin
        if (cur_state.flags[FlagZ]) begin
          pc_nxt = cur_state.pc + 16'd2;
          cost   = COST_8;
        end else begin
          pc_nxt = cur_state.pc + 16'd2 + jr_off;
          cost   = COST_12;
        end
      end
      default: begin
        ill = 1'b1;
      end
    endcase
    core_state.pc = pc_nxt;
  end

  // frame counter, left untouched by an illegal opcode
  assign cyc_sum = {1'b0, cur_state.frame_cycles} + {{(FcW + 1 - 5){1'b0}}, cost};
  assign fend    = !ill && (cyc_sum > {1'b0, frame_cycle_limit});

  always_comb begin
    result.next_pc     = ill ? cur_state.pc : pc_nxt;
    result.write_valid = wr_valid;
    result.write_addr  = wr_addr;
    result.write_data  = wr_data;
    result.cycle_cost  = cost;
    result.flags_out   = core_state.flags;
    result.frame_end   = fend;
    result.illegal     = ill;
  end

  always_comb begin
    new_state = core_state;
    if (ill) begin
      new_state.frame_cycles = cur_state.frame_cycles;
    end else if (fend) begin
      new_state.frame_cycles = '0;
    end else begin
      new_state.frame_cycles = cyc_sum[FcW-1:0];
    end
  end

endmodule
